// File: design/dual_role_space_shift_resolver_assert.svh
// assertion macros used by the checker file
`ifndef DUAL_ROLE_SPACE_SHIFT_RESOLVER_ASSERT_SVH
`define DUAL_ROLE_SPACE_SHIFT_RESOLVER_ASSERT_SVH

// same-cycle implication, reset masks the check
`define DSR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dsr assertion failed: same-cycle implication");

// next-cycle implication, reset masks the check
`define DSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dsr assertion failed: next-cycle implication");

`endif

// File: design/dsr_pkg.sv
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared types and constants of the dual-role space / right shift resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package dsr_pkg;

    // timer width, elapsed time wraps at this many bits
    localparam int TIME_BITS = 16;
    localparam int CFG_W     = 16;
    localparam int CODE_W    = 16;
    localparam int CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

    // apb port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // register indexes
    localparam logic [1:0] REG_TAP_TERM       = 2'd0;
    localparam logic [1:0] REG_OVERLAP_WINDOW = 2'd1;
    localparam logic [1:0] REG_DUAL_KEY_CODE  = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] RST_TAP_TERM       = 16'd200;
    localparam logic [CFG_W-1:0] RST_OVERLAP_WINDOW = 16'd50;
    localparam logic [CFG_W-1:0] RST_DUAL_KEY_CODE  = 16'd32259;

    // hid codes
    localparam logic [CODE_W-1:0] KC_SPC  = 16'h002C;
    localparam logic [CODE_W-1:0] KC_RSFT = 16'h00E5;
    localparam logic [CODE_W-1:0] KC_A    = 16'h0004;
    localparam logic [CODE_W-1:0] KC_Z    = 16'h001D;

    // job queue depth between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // at most three key actions per item, then the done item
    localparam int MAX_ACTS = 3;

    typedef enum logic [1:0] {
        ACT_REG   = 2'd0,
        ACT_UNREG = 2'd1,
        ACT_TAP   = 2'd2,
        ACT_DONE  = 2'd3
    } action_t;

    typedef struct packed {
        logic [CFG_W-1:0] tap_term;
        logic [CFG_W-1:0] overlap_window;
        logic [CFG_W-1:0] dual_key_code;
    } cfg_t;

    typedef struct packed {
        action_t           action;
        logic [CODE_W-1:0] code;
    } act_item_t;

    // one classified item: its key actions and the done verdict
    typedef struct packed {
        logic [1:0]                 count;
        act_item_t [MAX_ACTS-1:0]   items;
        logic                       pass_on;
    } job_t;

endpackage

`default_nettype wire

// File: design/dsr_front.sv
// ----------------------------------------------------------------------------
// dsr_front
// Accepts key events and scan ticks, keeps the resolver state and turns each
// item into a job of key actions plus the pass-on verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire dsr_pkg::cfg_t                   cfg,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            in_kind,
    input  wire logic [dsr_pkg::CODE_W-1:0]      in_key,
    input  wire logic                            in_pressed,
    input  wire logic [dsr_pkg::CODE_W-1:0]      in_now,
    output logic                                 job_valid,
    input  wire logic                            job_ready,
    output dsr_pkg::job_t                        job
);

    logic undecided_reg, undecided_next;
    logic prev_was_space_reg, prev_was_space_next;
    logic may_hold_space_reg, may_hold_space_next;
    logic release_as_space_reg, release_as_space_next;
    logic holding_space_reg, holding_space_next;
    logic [dsr_pkg::CODE_W-1:0]    buffered_key_reg, buffered_key_next;
    logic [dsr_pkg::TIME_BITS-1:0] press_stamp_reg, press_stamp_next;
    logic [dsr_pkg::TIME_BITS-1:0] buffered_stamp_reg, buffered_stamp_next;
    logic [dsr_pkg::TIME_BITS-1:0] space_tap_stamp_reg, space_tap_stamp_next;

    logic [dsr_pkg::TIME_BITS-1:0] now_t;
    logic [dsr_pkg::CMP_W-1:0]     since_press;
    logic [dsr_pkg::CMP_W-1:0]     since_buffered;
    logic [dsr_pkg::CMP_W-1:0]     since_tap;
    logic [dsr_pkg::CMP_W-1:0]     term;
    logic [dsr_pkg::CMP_W-1:0]     window;
    logic                          accept;
    logic                          is_dual;
    logic                          is_letter;
    logic                          has_buf;
    dsr_pkg::job_t                 job_c;

    assign accept    = in_valid && job_ready;
    assign in_ready  = job_ready;
    assign job_valid = in_valid;
    assign job       = job_c;

    // elapsed times, wrapping at the timer width
    assign now_t          = dsr_pkg::TIME_BITS'(in_now);
    assign since_press    = dsr_pkg::CMP_W'(dsr_pkg::TIME_BITS'(now_t - press_stamp_reg));
    assign since_buffered = dsr_pkg::CMP_W'(dsr_pkg::TIME_BITS'(now_t - buffered_stamp_reg));
    assign since_tap      = dsr_pkg::CMP_W'(dsr_pkg::TIME_BITS'(now_t - space_tap_stamp_reg));
    assign term           = dsr_pkg::CMP_W'(cfg.tap_term);
    assign window         = dsr_pkg::CMP_W'(cfg.overlap_window);

    assign is_dual   = (in_key == cfg.dual_key_code);
    assign is_letter = (in_key >= dsr_pkg::KC_A) && (in_key <= dsr_pkg::KC_Z);
    assign has_buf   = (buffered_key_reg != '0);

    // classify the item, build its job and the next resolver state
    always_comb
    begin
        undecided_next        = undecided_reg;
        prev_was_space_next   = prev_was_space_reg;
        may_hold_space_next   = may_hold_space_reg;
        release_as_space_next = release_as_space_reg;
        holding_space_next    = holding_space_reg;
        buffered_key_next     = buffered_key_reg;
        press_stamp_next      = press_stamp_reg;
        buffered_stamp_next   = buffered_stamp_reg;
        space_tap_stamp_next  = space_tap_stamp_reg;

        job_c.count   = 2'd0;
        job_c.pass_on = 1'b0;
        for (int i = 0; i < dsr_pkg::MAX_ACTS; i++)
        begin
            job_c.items[i].action = dsr_pkg::ACT_REG;
            job_c.items[i].code   = '0;
        end

        if (in_kind)
        begin
            // scan tick settles the role once the term has run out
            if (undecided_reg && (since_press > term))
            begin
                undecided_next = 1'b0;
                if (may_hold_space_reg)
                begin
                    holding_space_next    = 1'b1;
                    job_c.items[0].code   = dsr_pkg::KC_SPC;
                    release_as_space_next = 1'b1;
                end
                else
                begin
                    job_c.items[0].code   = dsr_pkg::KC_RSFT;
                    release_as_space_next = 1'b0;
                end
                job_c.items[1].code = buffered_key_reg;
                job_c.count         = has_buf ? 2'd2 : 2'd1;
            end
        end
        else if (!undecided_reg)
        begin
            if (is_dual)
            begin
                if (in_pressed)
                begin
                    may_hold_space_next   = prev_was_space_reg && (since_tap <= term);
                    prev_was_space_next   = 1'b0;
                    undecided_next        = 1'b1;
                    release_as_space_next = 1'b0;
                    buffered_key_next     = '0;
                    press_stamp_next      = now_t;
                    holding_space_next    = 1'b0;
                end
                else
                begin
                    job_c.items[0].action = dsr_pkg::ACT_UNREG;
                    job_c.items[0].code   = release_as_space_reg ? dsr_pkg::KC_SPC
                                                                 : dsr_pkg::KC_RSFT;
                    job_c.count           = 2'd1;
                    holding_space_next    = 1'b0;
                end
            end
            else
            begin
                // another key press ends a held space and turns it to shift
                if (holding_space_reg && in_pressed)
                begin
                    holding_space_next    = 1'b0;
                    job_c.items[0].action = dsr_pkg::ACT_UNREG;
                    job_c.items[0].code   = dsr_pkg::KC_SPC;
                    job_c.items[1].code   = dsr_pkg::KC_RSFT;
                    release_as_space_next = 1'b0;
                    job_c.count           = 2'd2;
                end
                job_c.pass_on = 1'b1;
            end
        end
        else
        begin
            undecided_next = 1'b0;
            if (in_pressed)
            begin
                may_hold_space_next = 1'b0;
                if (is_letter && !has_buf)
                begin
                    // hold the first letter back while undecided
                    undecided_next      = 1'b1;
                    buffered_key_next   = in_key;
                    buffered_stamp_next = now_t;
                end
                else
                begin
                    job_c.items[0].code   = dsr_pkg::KC_RSFT;
                    release_as_space_next = 1'b0;
                    job_c.items[1].code   = buffered_key_reg;
                    job_c.count           = has_buf ? 2'd2 : 2'd1;
                    job_c.pass_on         = 1'b1;
                end
            end
            else if (is_dual)
            begin
                if (has_buf)
                begin
                    if (since_buffered < window)
                    begin
                        job_c.items[0].action = dsr_pkg::ACT_TAP;
                        job_c.items[0].code   = dsr_pkg::KC_SPC;
                        job_c.items[1].code   = buffered_key_reg;
                        job_c.count           = 2'd2;
                    end
                    else
                    begin
                        job_c.items[0].code   = dsr_pkg::KC_RSFT;
                        job_c.items[1].code   = buffered_key_reg;
                        job_c.items[2].action = dsr_pkg::ACT_UNREG;
                        job_c.items[2].code   = dsr_pkg::KC_RSFT;
                        job_c.count           = 2'd3;
                    end
                end
                else if (since_press <= term)
                begin
                    job_c.items[0].action = dsr_pkg::ACT_TAP;
                    job_c.items[0].code   = dsr_pkg::KC_SPC;
                    job_c.count           = 2'd1;
                    prev_was_space_next   = 1'b1;
                    space_tap_stamp_next  = now_t;
                end
            end
            else if (has_buf && (in_key == buffered_key_reg))
            begin
                // buffered letter released first: shift plus the letter
                job_c.items[0].code   = dsr_pkg::KC_RSFT;
                release_as_space_next = 1'b0;
                job_c.items[1].action = dsr_pkg::ACT_TAP;
                job_c.items[1].code   = in_key;
                job_c.count           = 2'd2;
            end
            else
            begin
                // release of a key held from before: space
                release_as_space_next = 1'b1;
                job_c.items[0].code   = dsr_pkg::KC_SPC;
                job_c.items[1].code   = buffered_key_reg;
                job_c.count           = has_buf ? 2'd2 : 2'd1;
                job_c.pass_on         = 1'b1;
            end
        end
    end

    // resolver state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            undecided_reg        <= 1'b0;
            prev_was_space_reg   <= 1'b0;
            may_hold_space_reg   <= 1'b0;
            release_as_space_reg <= 1'b0;
            holding_space_reg    <= 1'b0;
            buffered_key_reg     <= '0;
            press_stamp_reg      <= '0;
            buffered_stamp_reg   <= '0;
            space_tap_stamp_reg  <= '0;
        end
        else if (accept)
        begin
            undecided_reg        <= undecided_next;
            prev_was_space_reg   <= prev_was_space_next;
            may_hold_space_reg   <= may_hold_space_next;
            release_as_space_reg <= release_as_space_next;
            holding_space_reg    <= holding_space_next;
            buffered_key_reg     <= buffered_key_next;
            press_stamp_reg      <= press_stamp_next;
            buffered_stamp_reg   <= buffered_stamp_next;
            space_tap_stamp_reg  <= space_tap_stamp_next;
        end
    end

endmodule

`default_nettype wire

// File: design/dsr_queue.sv
// ----------------------------------------------------------------------------
// dsr_queue
// Short job queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire dsr_pkg::job_t push_job,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output dsr_pkg::job_t      pop_job
);

    dsr_pkg::job_t mem [dsr_pkg::QUEUE_DEPTH];

    logic [dsr_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dsr_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dsr_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       push;
    logic                       pop;

    assign push_ready = (count_reg != dsr_pkg::QCNT_W'(dsr_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == dsr_pkg::QPTR_W'(dsr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == dsr_pkg::QPTR_W'(dsr_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// File: design/dsr_back.sv
// ----------------------------------------------------------------------------
// dsr_back
// Walks the head job into the output register, one result per unstalled cycle:
// the key actions in order, then the done item with the pass-on verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        job_valid,
    output logic                             job_ready,
    input  wire dsr_pkg::job_t               job,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output dsr_pkg::action_t                 out_action,
    output logic [dsr_pkg::CODE_W-1:0]       out_code,
    output logic                             out_pass_on,
    output logic                             out_last
);

    logic [1:0]                 idx_reg, idx_next;
    logic                       valid_reg, valid_next;
    dsr_pkg::action_t           action_reg;
    logic [dsr_pkg::CODE_W-1:0] code_reg;
    logic                       pass_on_reg;
    logic                       last_reg;

    logic                       load;
    logic                       at_done;
    dsr_pkg::act_item_t         cur_item;

    assign at_done   = (idx_reg == job.count);
    assign load      = job_valid && (!valid_reg || out_ready);
    assign job_ready = load && at_done;

    // pick the current action of the head job
    always_comb
    begin
        case (idx_reg)
            2'd0:    cur_item = job.items[0];
            2'd1:    cur_item = job.items[1];
            2'd2:    cur_item = job.items[2];
            default: cur_item = job.items[0];
        endcase
    end

    // step through the job, hold the output while stalled
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !out_ready;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = at_done ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (at_done)
            begin
                action_reg  <= dsr_pkg::ACT_DONE;
                code_reg    <= '0;
                pass_on_reg <= job.pass_on;
                last_reg    <= 1'b1;
            end
            else
            begin
                action_reg  <= cur_item.action;
                code_reg    <= cur_item.code;
                pass_on_reg <= 1'b0;
                last_reg    <= 1'b0;
            end
        end
    end

    assign out_valid   = valid_reg;
    assign out_action  = action_reg;
    assign out_code    = code_reg;
    assign out_pass_on = pass_on_reg;
    assign out_last    = last_reg;

endmodule

`default_nettype wire

// File: design/dual_role_space_shift_resolver.sv
// An item's first result is held in the job queue, then in the output register.
// Throughput: an item yields one to four results, one per cycle on the output
// register while the result port is not stalled; a new item is taken every cycle
// while the two-entry job queue has room, so the output port sets the sustained rate.
// Reset: rst_n clears resolver state, queue and output valid at once, and
// loads the registers with their defaults; no clearing pass.
// ----------------------------------------------------------------------------
// dual_role_space_shift_resolver
// Dual-role space / right shift key resolver with apb configuration and
// stream ports: front classifier, job queue and result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_role_space_shift_resolver (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // apb configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [dsr_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [dsr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dsr_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                    pready,
    // input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [39:0]                        s_tdata,  // key_code, pressed, now_ms
    input  wire logic                               s_tuser,  // kind
    // result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [23:0]                             m_tdata,  // out_code, pass_on
    output logic [1:0]                              m_tuser,  // action
    output logic                                    m_tlast
);

    logic [dsr_pkg::CFG_W-1:0] tap_term_reg;
    logic [dsr_pkg::CFG_W-1:0] overlap_window_reg;
    logic [dsr_pkg::CFG_W-1:0] dual_key_code_reg;
    logic [1:0]                reg_index;
    logic                      cfg_write;
    dsr_pkg::cfg_t             cfg;

    logic                       fq_valid;
    logic                       fq_ready;
    dsr_pkg::job_t              fq_job;
    logic                       qb_valid;
    logic                       qb_ready;
    dsr_pkg::job_t              qb_job;
    dsr_pkg::action_t           res_action;
    logic [dsr_pkg::CODE_W-1:0] res_code;
    logic                       res_pass_on;

    // configuration registers
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_term_reg       <= dsr_pkg::RST_TAP_TERM;
            overlap_window_reg <= dsr_pkg::RST_OVERLAP_WINDOW;
            dual_key_code_reg  <= dsr_pkg::RST_DUAL_KEY_CODE;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                dsr_pkg::REG_TAP_TERM:       tap_term_reg       <= pwdata[15:0];
                dsr_pkg::REG_OVERLAP_WINDOW: overlap_window_reg <= pwdata[15:0];
                dsr_pkg::REG_DUAL_KEY_CODE:  dual_key_code_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (reg_index)
            dsr_pkg::REG_TAP_TERM:       prdata = dsr_pkg::APB_DATA_W'(tap_term_reg);
            dsr_pkg::REG_OVERLAP_WINDOW: prdata = dsr_pkg::APB_DATA_W'(overlap_window_reg);
            dsr_pkg::REG_DUAL_KEY_CODE:  prdata = dsr_pkg::APB_DATA_W'(dual_key_code_reg);
            default:                     prdata = '0;
        endcase
    end

    assign cfg.tap_term       = tap_term_reg;
    assign cfg.overlap_window = overlap_window_reg;
    assign cfg.dual_key_code  = dual_key_code_reg;

    // front: classify items and update resolver state
    dsr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser),
        .in_key     (s_tdata[15:0]),
        .in_pressed (s_tdata[16]),
        .in_now     (s_tdata[32:17]),
        .job_valid  (fq_valid),
        .job_ready  (fq_ready),
        .job        (fq_job)
    );

    // job queue
    dsr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    // back: emit results
    dsr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (qb_valid),
        .job_ready   (qb_ready),
        .job         (qb_job),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_action  (res_action),
        .out_code    (res_code),
        .out_pass_on (res_pass_on),
        .out_last    (m_tlast)
    );

    assign m_tuser = res_action;
    assign m_tdata = {7'd0, res_pass_on, res_code};

endmodule

`default_nettype wire

// File: design/dsr_checker.sv
// ----------------------------------------------------------------------------
// dsr_port_checker
// Port-level checks of the resolver's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_role_space_shift_resolver_assert.svh"

module dsr_port_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [23:0]                    m_tdata,
    input  wire logic [1:0]                     m_tuser,
    input  wire logic                           m_tlast
);

    // whole result payload
    logic [26:0] payload;

    assign payload = {m_tlast, m_tuser, m_tdata};

    // a stalled result holds its payload
    `DSR_ASSERT_NEXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(payload))

    // tlast marks exactly the done item
    `DSR_ASSERT_IMPL(a_last_is_done, clk, rst_n, m_tvalid, m_tlast == (m_tuser == dsr_pkg::ACT_DONE))

    // key actions carry no pass-on verdict
    `DSR_ASSERT_IMPL(a_action_no_pass, clk, rst_n, m_tvalid && !m_tlast, m_tdata[16] == 1'b0)

    // done items carry a zero code
    `DSR_ASSERT_IMPL(a_done_zero_code, clk, rst_n, m_tvalid && m_tlast, m_tdata[15:0] == 16'd0)

endmodule

bind dual_role_space_shift_resolver dsr_port_checker u_dsr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
